// ===== rtl/ple_pkg.sv =====
// Package for the positional list engine: operation and status codes,
// default sizes and the control bundle broadcast to the storage cells.
// No dependencies.
`default_nettype none
package ple_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_READ   = 3'd2;
	localparam logic [2:0] MODE_WRITE  = 3'd3;
	localparam logic [2:0] MODE_FIND   = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BADPOS   = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef struct packed {
		logic upd;
		logic ins;
		logic rem;
		logic wr;
		logic fnd;
	} ple_cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ple_req_if.sv =====
// Request channel of the positional list engine.
// Carries valid, ready and the request payload; no dependencies.
`default_nettype none
interface ple_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [8:0]         position;
	logic signed [31:0] value;

	modport source (output valid, mode, position, value, input ready);
	modport sink (input valid, mode, position, value, output ready);
endinterface
`default_nettype wire

// ===== rtl/ple_rsp_if.sv =====
// Response channel of the positional list engine.
// Carries valid, ready and the response payload; no dependencies.
`default_nettype none
interface ple_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic [8:0]         count;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, status, data_out, count, is_empty, is_full, input ready);
	modport sink (input valid, status, data_out, count, is_empty, is_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/ple_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts with its
// neighbors and flags a position or value match. Depends on ple_pkg.
`default_nettype none
module ple_cell #(
	parameter int IDX   = 0,
	parameter int DW    = 32,
	parameter int IW    = 8,
	parameter int CNT_W = 9
) (
	input  wire logic                   clk,
	input  wire ple_pkg::ple_cell_ctl_t ctl,
	input  wire logic [IW-1:0]          pos0,
	input  wire logic [CNT_W-1:0]       count,
	input  wire logic [DW-1:0]          word,
	input  wire logic [DW-1:0]          left,
	input  wire logic [DW-1:0]          right,
	output logic [DW-1:0]               data,
	output logic                        hit
);
	import ple_pkg::*;

	logic [DW-1:0] data_q;
	logic          at_pos;
	logic          past_pos;
	logic          in_list;

	assign at_pos   = (pos0 == IW'(IDX));
	assign past_pos = (pos0 < IW'(IDX));
	assign in_list  = (CNT_W'(IDX) < count);
	assign hit      = ctl.fnd ? (in_list && (data_q == word)) : at_pos;
	assign data     = data_q;

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			if (ctl.ins) begin
				if (past_pos) begin
					data_q <= left;
				end else if (at_pos) begin
					data_q <= word;
				end
			end else if (ctl.rem) begin
				if (past_pos || at_pos) begin
					data_q <= right;
				end
			end else if (ctl.wr && at_pos) begin
				data_q <= word;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ple_tree.sv =====
// Registered binary reduction tree that picks the leftmost flagged cell
// and its word; every tree level is registered. Depends on ple_pkg.
`default_nettype none
module ple_tree #(
	parameter int N2 = 256,
	parameter int DW = 32,
	parameter int IW = 8
) (
	input  wire logic                  clk,
	input  wire logic [N2-1:0]         leaf_hit,
	input  wire logic [N2-1:0][DW-1:0] leaf_data,
	output logic                       root_hit,
	output logic [IW-1:0]              root_idx,
	output logic [DW-1:0]              root_data
);
	import ple_pkg::*;

	localparam int NI = N2 - 1;
	localparam int NT = 2 * N2 - 1;

	logic          all_hit  [NT];
	logic [IW-1:0] all_idx  [NT];
	logic [DW-1:0] all_data [NT];

	logic          node_hit_q  [NI];
	logic [IW-1:0] node_idx_q  [NI];
	logic [DW-1:0] node_data_q [NI];

	for (genvar k = 0; k < NT; k++) begin : g_node
		if (k < NI) begin : g_inner
			always_ff @(posedge clk) begin
				node_hit_q[k] <= all_hit[2*k+1] || all_hit[2*k+2];
				if (all_hit[2*k+1]) begin
					node_idx_q[k]  <= all_idx[2*k+1];
					node_data_q[k] <= all_data[2*k+1];
				end else begin
					node_idx_q[k]  <= all_idx[2*k+2];
					node_data_q[k] <= all_data[2*k+2];
				end
			end
			assign all_hit[k]  = node_hit_q[k];
			assign all_idx[k]  = node_idx_q[k];
			assign all_data[k] = node_data_q[k];
		end else begin : g_leaf
			assign all_hit[k]  = leaf_hit[k-NI];
			assign all_idx[k]  = IW'(k - NI);
			assign all_data[k] = leaf_data[k-NI];
		end
	end

	assign root_hit  = all_hit[0];
	assign root_idx  = all_idx[0];
	assign root_data = all_data[0];

endmodule
`default_nettype wire

// ===== rtl/positional_list_engine_core.sv =====
// A request accepted at one edge waits in S_WAIT while the registered match tree settles;
// LVL = clog2(CAPACITY) is the depth of that tree (8 at 256). One request is in flight
// at a time; a new request is taken in the cycle its predecessor's response is taken
// or while idle. Reset clears the entry count and the sequencer;
// entry words are not cleared and need no clearing pass.
// Depends on ple_pkg, ple_req_if, ple_rsp_if, ple_cell and ple_tree.
`default_nettype none
module positional_list_engine_core #(
	parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);
	import ple_pkg::*;

	localparam int LVL   = (CAPACITY <= 2) ? 1 : $clog2(CAPACITY);
	localparam int N2    = 1 << LVL;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = ((CNT_W > 9) ? CNT_W : 9) + 1;
	localparam int WC_W  = $clog2(LVL + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WAIT = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                   state_q;
	logic [WC_W-1:0]          wc_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [2:0]               mode_q;
	logic [LVL-1:0]           pos0_q;
	logic [DATA_WIDTH-1:0]    word_q;
	logic [1:0]               st_q;
	logic                     ok_q;
	logic [1:0]               status_q;
	logic [31:0]              data_out_q;

	logic                     acc;
	logic                     commit;
	logic [PW-1:0]            pos_x;
	logic [PW-1:0]            cnt_x;
	logic                     pos_in;
	logic                     pos_ins;
	logic [1:0]               st_d;
	logic [CNT_W-1:0]         cnt_d;
	logic [1:0]               status_d;
	logic [31:0]              data_out_d;
	ple_cell_ctl_t            ctl;

	logic [DATA_WIDTH-1:0]    cell_data [CAPACITY];
	logic [N2-1:0]            leaf_hit;
	logic [N2-1:0][DATA_WIDTH-1:0] leaf_data;
	logic                     root_hit;
	logic [LVL-1:0]           root_idx;
	logic [DATA_WIDTH-1:0]    root_data;

	assign req.ready = (state_q == S_IDLE) || ((state_q == S_DONE) && rsp.ready);
	assign acc       = req.valid && req.ready;
	assign commit    = (state_q == S_WAIT) && (wc_q == WC_W'(LVL));

	assign pos_x   = PW'(req.position);
	assign cnt_x   = PW'(cnt_q);
	assign pos_in  = (pos_x != '0) && (pos_x <= cnt_x);
	assign pos_ins = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));

	always_comb begin
		case (req.mode)
			MODE_INSERT: begin
				if (!pos_ins) begin
					st_d = STAT_BADPOS;
				end else if (cnt_q == CNT_W'(CAPACITY)) begin
					st_d = STAT_FULL;
				end else begin
					st_d = STAT_OK;
				end
			end
			MODE_REMOVE, MODE_READ, MODE_WRITE: begin
				st_d = pos_in ? STAT_OK : STAT_BADPOS;
			end
			MODE_FIND: begin
				st_d = STAT_OK;
			end
			default: begin
				st_d = STAT_BADPOS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wc_q    <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_WAIT;
						wc_q    <= '0;
					end
				end
				S_WAIT: begin
					if (commit) begin
						state_q <= S_DONE;
						cnt_q   <= cnt_d;
					end else begin
						wc_q <= wc_q + WC_W'(1);
					end
				end
				S_DONE: begin
					if (acc) begin
						state_q <= S_WAIT;
						wc_q    <= '0;
					end else if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= req.mode;
			pos0_q <= LVL'(req.position - 9'd1);
			word_q <= DATA_WIDTH'(req.value);
			st_q   <= st_d;
			ok_q   <= (st_d == STAT_OK);
		end
		if (commit) begin
			status_q   <= status_d;
			data_out_q <= data_out_d;
		end
	end

	always_comb begin
		cnt_d      = cnt_q;
		status_d   = st_q;
		data_out_d = '0;
		case (mode_q)
			MODE_INSERT: begin
				if (ok_q) begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (ok_q) begin
					cnt_d      = cnt_q - CNT_W'(1);
					data_out_d = 32'(root_data);
				end
			end
			MODE_READ: begin
				if (ok_q) begin
					data_out_d = 32'(root_data);
				end
			end
			MODE_WRITE: begin
				status_d = st_q;
			end
			MODE_FIND: begin
				if (root_hit) begin
					status_d   = STAT_OK;
					data_out_d = 32'(root_idx) + 32'd1;
				end else begin
					status_d = STAT_NOTFOUND;
				end
			end
			default: begin
				status_d = STAT_BADPOS;
			end
		endcase
	end

	assign ctl.upd = commit && ok_q;
	assign ctl.ins = (mode_q == MODE_INSERT);
	assign ctl.rem = (mode_q == MODE_REMOVE);
	assign ctl.wr  = (mode_q == MODE_WRITE);
	assign ctl.fnd = (mode_q == MODE_FIND);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = word_q;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_body
			assign right_w = cell_data[i+1];
		end
		ple_cell #(
			.IDX   (i),
			.DW    (DATA_WIDTH),
			.IW    (LVL),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos0  (pos0_q),
			.count (cnt_q),
			.word  (word_q),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.hit   (leaf_hit[i])
		);
		assign leaf_data[i] = cell_data[i];
	end

	for (genvar j = CAPACITY; j < N2; j++) begin : g_pad
		assign leaf_hit[j]  = 1'b0;
		assign leaf_data[j] = '0;
	end

	ple_tree #(
		.N2 (N2),
		.DW (DATA_WIDTH),
		.IW (LVL)
	) u_tree (
		.clk       (clk),
		.leaf_hit  (leaf_hit),
		.leaf_data (leaf_data),
		.root_hit  (root_hit),
		.root_idx  (root_idx),
		.root_data (root_data)
	);

	assign rsp.valid    = (state_q == S_DONE);
	assign rsp.status   = status_q;
	assign rsp.data_out = data_out_q;
	assign rsp.count    = 9'(cnt_q);
	assign rsp.is_empty = (cnt_q == '0);
	assign rsp.is_full  = (cnt_q == CNT_W'(CAPACITY));

	// The entry count never exceeds the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The entry count only moves on a commit.
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(cnt_q))
		else $error("entry count changed outside a commit");

	// A successful insert adds exactly one entry.
	a_ins_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && ok_q && (mode_q == MODE_INSERT)) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("insert did not add one entry");

	// A response appears only after the match tree has been waited out.
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(commit))
		else $error("response raised without a commit");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for positional_list_engine_core: random and directed list requests,
// with responses checked against an in-bench model of the list.
// Depends on ple_pkg, ple_req_if, ple_rsp_if and the engine RTL.
`timescale 1ns / 100ps
module tb;
	import ple_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int POS_MAX = CAP + 1;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] MODE_UNUSED_A = 3'd5;
	localparam logic [2:0] MODE_UNUSED_B = 3'd6;
	localparam logic [2:0] MODE_UNUSED_C = 3'd7;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [8:0]         count;
		logic               is_empty;
		logic               is_full;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	ple_req_if req();
	ple_rsp_if rsp();

	positional_list_engine_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic signed [31:0] list_words [CAP];
	int list_len = 0;
	list_rsp_t expected_answers [$];
	int error_count = 0;
	int quiet_cycles = 0;
	bit sender_gaps = 1'b1;
	bit receiver_gaps = 1'b1;
	bit hold_request = 1'b0;

	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		if (error_count < 50) $display("[%0t] ERROR: %s", $time, msg);
		error_count++;
	endtask

	function automatic list_rsp_t apply_list_op(input logic [2:0] op, input logic [8:0] pos,
			input logic signed [31:0] val);
		list_rsp_t r;
		int p;
		int i;
		p = pos;
		r.status = STAT_OK;
		r.data = '0;
		case (op)
			MODE_INSERT: begin
				if (p == 0 || p > list_len + 1) begin
					r.status = STAT_BADPOS;
				end else if (list_len >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (i = list_len; i >= p; i--) list_words[i] = list_words[i - 1];
					list_words[p - 1] = val;
					list_len++;
				end
			end
			MODE_REMOVE: begin
				if (p == 0 || p > list_len) begin
					r.status = STAT_BADPOS;
				end else begin
					r.data = list_words[p - 1];
					list_len--;
					for (i = p - 1; i < list_len; i++) list_words[i] = list_words[i + 1];
				end
			end
			MODE_READ: begin
				if (p == 0 || p > list_len) r.status = STAT_BADPOS;
				else r.data = list_words[p - 1];
			end
			MODE_WRITE: begin
				if (p == 0 || p > list_len) r.status = STAT_BADPOS;
				else list_words[p - 1] = val;
			end
			MODE_FIND: begin
				r.status = STAT_NOTFOUND;
				for (i = 0; i < list_len && r.status != STAT_OK; i++) begin
					if (list_words[i] == val) begin
						r.status = STAT_OK;
						r.data = 32'(i + 1);
					end
				end
			end
			default: begin
				r.status = STAT_BADPOS;
			end
		endcase
		r.count = 9'(list_len);
		r.is_empty = (list_len == 0);
		r.is_full = (list_len == CAP);
		return r;
	endfunction

	function automatic logic signed [31:0] random_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30 && list_len > 0) return list_words[$urandom_range(list_len - 1)];
		if (pick < 50) return $signed(32'($urandom_range(7))) - 32'sd3;
		if (pick < 55) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		return $urandom;
	endfunction

	task automatic send_req(input logic [2:0] op, input logic [8:0] pos,
			input logic signed [31:0] val);
		while (sender_gaps && ($urandom_range(99) < 38)) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= op;
		req.position <= pos;
		req.value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		expected_answers.push_back(apply_list_op(op, pos, val));
	endtask

	task automatic send_random_op();
		int pick;
		int ins_w;
		int lim;
		int p;
		logic [2:0] op;
		ins_w = (list_len < CAP / 4) ? 35 : ((list_len > 3 * CAP / 4) ? 15 : 25);
		pick = $urandom_range(99);
		if (pick < 2) op = 3'($urandom_range(MODE_UNUSED_C, MODE_UNUSED_A));
		else if (pick < 2 + ins_w) op = MODE_INSERT;
		else if (pick < 52) op = MODE_REMOVE;
		else if (pick < 68) op = MODE_READ;
		else if (pick < 84) op = MODE_WRITE;
		else op = MODE_FIND;
		lim = (op == MODE_INSERT) ? list_len + 1 : list_len;
		if ($urandom_range(99) < 85 && lim > 0) p = $urandom_range(lim, 1);
		else if (lim >= POS_MAX || $urandom_range(1)) p = 0;
		else p = $urandom_range(POS_MAX, lim + 1);
		send_req(op, 9'(p), random_value());
	endtask

	task automatic check_response();
		list_rsp_t want;
		if (expected_answers.size() == 0) begin
			report_error("response with no request outstanding");
			return;
		end
		want = expected_answers.pop_front();
		if (rsp.status !== want.status)
			report_error($sformatf("status: got %0d, expected %0d", rsp.status, want.status));
		if (rsp.data_out !== want.data)
			report_error($sformatf("data_out: got %0d, expected %0d", rsp.data_out, want.data));
		if (rsp.count !== want.count)
			report_error($sformatf("count: got %0d, expected %0d", rsp.count, want.count));
		if (rsp.is_empty !== want.is_empty)
			report_error($sformatf("is_empty: got %b, expected %b", rsp.is_empty, want.is_empty));
		if (rsp.is_full !== want.is_full)
			report_error($sformatf("is_full: got %b, expected %b", rsp.is_full, want.is_full));
	endtask

	initial begin : response_side
		int hold_left;
		hold_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) check_response();
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (receiver_gaps) begin
				rsp.ready <= ($urandom_range(99) >= 38);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_req(MODE_READ, 9'd1, 32'sd0);
		send_req(MODE_REMOVE, 9'd0, 32'sd0);
		send_req(MODE_WRITE, 9'd1, 32'sd9);
		send_req(MODE_FIND, 9'd0, 32'sd0);
		send_req(MODE_INSERT, 9'd0, 32'sd1);
		send_req(MODE_INSERT, 9'd2, 32'sd1);
		send_req(MODE_INSERT, 9'd1, 32'h8000_0000);
		send_req(MODE_INSERT, 9'd2, 32'h7FFF_FFFF);
		send_req(MODE_INSERT, 9'd1, 32'sd0);
		send_req(MODE_INSERT, 9'd4, -32'sd1);
		send_req(MODE_INSERT, 9'(POS_MAX), 32'sd5);
		send_req(MODE_READ, 9'd1, 32'sd0);
		send_req(MODE_READ, 9'd4, 32'sd0);
		send_req(MODE_READ, 9'd5, 32'sd0);
		send_req(MODE_WRITE, 9'd2, 32'h5A5A_A5A5);
		send_req(MODE_INSERT, 9'd3, -32'sd1);
		send_req(MODE_FIND, 9'd0, -32'sd1);
		send_req(MODE_FIND, 9'(POS_MAX), 32'h1234_5678);
		send_req(MODE_UNUSED_A, 9'(CAP), 32'sd0);
		send_req(MODE_UNUSED_B, 9'd1, 32'sd0);
		send_req(MODE_UNUSED_C, 9'(POS_MAX), -32'sd1);
		send_req(MODE_REMOVE, 9'd1, 32'sd0);
		send_req(MODE_REMOVE, 9'd4, 32'sd0);
		send_req(MODE_REMOVE, 9'(CAP), 32'sd0);
		send_req(MODE_READ, 9'd0, 32'sd0);
	endtask

	task automatic test_fill_and_drain();
		while (list_len < CAP) begin
			if ($urandom_range(99) < 70)
				send_req(MODE_INSERT, 9'($urandom_range(list_len + 1, 1)), random_value());
			else
				send_random_op();
		end
		send_req(MODE_INSERT, 9'(POS_MAX), random_value());
		send_req(MODE_INSERT, 9'd1, random_value());
		send_req(MODE_READ, 9'(CAP), 32'sd0);
		send_req(MODE_WRITE, 9'(CAP), random_value());
		send_req(MODE_REMOVE, 9'(POS_MAX), 32'sd0);
		send_req(MODE_FIND, 9'd0, list_words[CAP - 1]);
		while (list_len > 0) begin
			if ($urandom_range(99) < 70)
				send_req(MODE_REMOVE, 9'($urandom_range(list_len, 1)), random_value());
			else
				send_random_op();
		end
		send_req(MODE_REMOVE, 9'd1, 32'sd0);
	endtask

	task automatic test_random_mix(input int n);
		repeat (n) send_random_op();
	endtask

	task automatic test_back_to_back(input int n);
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		repeat (n) send_random_op();
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	task automatic test_output_stall(input int n);
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (n) send_random_op();
		sender_gaps = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.mode <= MODE_READ;
		req.position <= '0;
		req.value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_drain();
		test_random_mix(350);
		test_back_to_back(150);
		test_output_stall(40);
		req.valid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
